/* rtl/core/utf8d_pkg.sv */
// utf8d_pkg: shared types, constants and the lead-byte length function
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int VALUE_W = 31;
    localparam int COUNT_W = 3;
    localparam int BYTE_W  = 8;

    localparam int MAX_SEQ_BYTES_DEFAULT = 6;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    localparam logic [BYTE_W-1:0] CONT_MASK     = 8'h3F;
    localparam logic [BYTE_W-1:0] CONT_FLAG     = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_MASK_ALL = 8'hFF;

    localparam logic [COUNT_W-1:0] ONE_BYTE = 3'd1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               trunc;
    } res_t;

    // up to two results caused by one input item
    typedef struct packed {
        res_t first;
        res_t second;
        logic two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // sequence length of a starting byte: its run of leading ones if that is 2 to max_len, else 1
    function automatic logic [COUNT_W-1:0] seq_len(input logic [BYTE_W-1:0] b,
                                                   input logic [3:0] max_len);
        logic [3:0] run;
        logic       stop;
        run  = 4'd0;
        stop = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (!stop && b[i])
                run = run + 4'd1;
            else
                stop = 1'b1;
        end
        if (run >= 4'd2 && run <= max_len)
            return run[COUNT_W-1:0];
        return ONE_BYTE;
    endfunction

endpackage

/* rtl/core/utf8_style_value_decoder.sv */
// utf8_style_value_decoder: top level of the six-byte utf-8 style value decoder
`timescale 1ns / 1ps

// Decodes a byte stream in the original six-byte UTF-8 form into values of up
// to 31 bits. One byte is accepted per cycle as long as the result queue has
// room; the front updates the pending sequence in the cycle the byte is taken
// and queues the zero, one or two results it causes. The back hands out one
// result per cycle from its output register while out_ready is high; an item
// that causes two results (a bad second byte followed by a raw or flushed
// value) holds the back until both are out. An accepted byte's first result
// passes a queue entry, then the output register. last_of_run is set on the
// final result of each input byte; a byte that causes no result gives none.
module utf8_style_value_decoder #(
    parameter int MAX_SEQ_BYTES = utf8d_pkg::MAX_SEQ_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH   = utf8d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]   data_byte,
    input  logic                           end_of_stream,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [utf8d_pkg::VALUE_W-1:0]  code_value,
    output logic [utf8d_pkg::COUNT_W-1:0]  byte_count,
    output logic                           truncated,
    output logic                           last_of_run
);

    utf8d_pkg::q_stat_t q_stat;
    utf8d_pkg::entry_t  push_entry;
    utf8d_pkg::entry_t  pop_entry;
    logic               push;
    logic               pop;

    utf8d_front #(
        .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_stream(end_of_stream),
        .q_stat       (q_stat),
        .push         (push),
        .push_entry   (push_entry)
    );

    utf8d_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .pop_entry (pop_entry),
        .q_stat    (q_stat)
    );

    utf8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_value (code_value),
        .byte_count (byte_count),
        .truncated  (truncated),
        .last_of_run(last_of_run)
    );

endmodule

/* rtl/core/utf8d_front.sv */
// utf8d_front: accepts bytes, tracks the pending sequence and packs results per item
`timescale 1ns / 1ps

module utf8d_front #(
    parameter int MAX_SEQ_BYTES = utf8d_pkg::MAX_SEQ_BYTES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          end_of_stream,
    input  utf8d_pkg::q_stat_t            q_stat,
    output logic                          push,
    output utf8d_pkg::entry_t             push_entry
);

    logic [utf8d_pkg::COUNT_W-1:0] exp_len_reg, exp_len_next;
    logic [utf8d_pkg::COUNT_W-1:0] taken_reg, taken_next;
    logic [utf8d_pkg::VALUE_W-1:0] partial_reg, partial_next;
    logic [utf8d_pkg::BYTE_W-1:0]  lead_reg, lead_next;

    logic                          accept;
    logic [utf8d_pkg::COUNT_W-1:0] len;
    logic [3:0]                    shamt;
    logic [utf8d_pkg::BYTE_W-1:0]  lead_bits;
    logic [utf8d_pkg::COUNT_W-1:0] taken_inc;
    utf8d_pkg::res_t               r0, r1, rn;
    logic [1:0]                    cnt;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    assign len       = utf8d_pkg::seq_len(data_byte, 4'(MAX_SEQ_BYTES));
    assign shamt     = {1'b0, len} + 4'd1;
    assign lead_bits = data_byte & (utf8d_pkg::LEAD_MASK_ALL >> shamt);
    assign taken_inc = taken_reg + 3'd1;

    always_comb
    begin
        exp_len_next = exp_len_reg;
        taken_next   = taken_reg;
        partial_next = partial_reg;
        lead_next    = lead_reg;
        r0           = '0;
        r1           = '0;
        rn           = '0;
        cnt          = 2'd0;

        if (exp_len_reg != '0 && !(taken_reg == 3'd1 && (data_byte & utf8d_pkg::CONT_FLAG) == '0))
        begin
            // continuation byte: append its low six bits
            partial_next = {partial_reg[utf8d_pkg::VALUE_W-7:0],
                            data_byte[5:0] & utf8d_pkg::CONT_MASK[5:0]};
            taken_next   = taken_inc;
            if (taken_inc >= exp_len_reg)
            begin
                rn = '{value: partial_next, count: exp_len_reg, trunc: 1'b0};
                r0 = rn;
                cnt = 2'd1;
                exp_len_next = '0;
                taken_next   = '0;
                partial_next = '0;
                lead_next    = '0;
            end
        end
        else
        begin
            if (exp_len_reg != '0)
            begin
                // bad second byte: lead goes out raw, this byte starts afresh
                rn = '{value: utf8d_pkg::VALUE_W'(lead_reg), count: utf8d_pkg::ONE_BYTE,
                       trunc: 1'b0};
                r0 = rn;
                cnt = 2'd1;
                exp_len_next = '0;
                taken_next   = '0;
                partial_next = '0;
                lead_next    = '0;
            end
            if (len == utf8d_pkg::ONE_BYTE)
            begin
                rn = '{value: utf8d_pkg::VALUE_W'(data_byte), count: utf8d_pkg::ONE_BYTE,
                       trunc: 1'b0};
                if (cnt == 2'd0)
                    r0 = rn;
                else
                    r1 = rn;
                cnt = cnt + 2'd1;
            end
            else
            begin
                exp_len_next = len;
                taken_next   = 3'd1;
                partial_next = utf8d_pkg::VALUE_W'(lead_bits);
                lead_next    = data_byte;
            end
        end

        // end of stream flushes whatever is still pending
        if (end_of_stream && exp_len_next != '0)
        begin
            rn = '{value: partial_next, count: taken_next, trunc: 1'b1};
            if (cnt == 2'd0)
                r0 = rn;
            else
                r1 = rn;
            cnt = cnt + 2'd1;
            exp_len_next = '0;
            taken_next   = '0;
            partial_next = '0;
            lead_next    = '0;
        end
    end

    assign push       = accept && (cnt != 2'd0);
    assign push_entry = '{first: r0, second: r1, two: (cnt == 2'd2)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
            taken_reg   <= '0;
            partial_reg <= '0;
            lead_reg    <= '0;
        end
        else if (accept)
        begin
            exp_len_reg <= exp_len_next;
            taken_reg   <= taken_next;
            partial_reg <= partial_next;
            lead_reg    <= lead_next;
        end
    end

endmodule

/* rtl/core/utf8d_queue.sv */
// utf8d_queue: small fifo of packed result entries between front and back
`timescale 1ns / 1ps

module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  utf8d_pkg::entry_t  push_entry,
    input  logic               pop,
    output utf8d_pkg::entry_t  pop_entry,
    output utf8d_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* rtl/core/utf8d_back.sv */
// utf8d_back: unpacks queue entries into single results behind an output register
`timescale 1ns / 1ps

module utf8d_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  utf8d_pkg::q_stat_t             q_stat,
    input  utf8d_pkg::entry_t              pop_entry,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [utf8d_pkg::VALUE_W-1:0]  code_value,
    output logic [utf8d_pkg::COUNT_W-1:0]  byte_count,
    output logic                           truncated,
    output logic                           last_of_run
);

    logic            out_valid_reg;
    utf8d_pkg::res_t out_res_reg;
    logic            out_last_reg;
    logic            pend_valid_reg;
    utf8d_pkg::res_t pend_res_reg;
    logic            advance;

    // output slot is free or its item leaves this cycle
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !pend_valid_reg && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_res_reg    <= '0;
            out_last_reg   <= 1'b0;
            pend_res_reg   <= '0;
        end
        else if (advance)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_res_reg    <= pend_res_reg;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (!q_stat.empty)
            begin
                out_valid_reg  <= 1'b1;
                out_res_reg    <= pop_entry.first;
                out_last_reg   <= !pop_entry.two;
                pend_valid_reg <= pop_entry.two;
                pend_res_reg   <= pop_entry.second;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_value  = out_res_reg.value;
    assign byte_count  = out_res_reg.count;
    assign truncated   = out_res_reg.trunc;
    assign last_of_run = out_last_reg;

endmodule
